// ===== hw/rtl/dsa_pkg.sv =====
// dsa_pkg: shared types, constants and the cordic arctangent table
// used by the calibration stage, cordic cells and the top level
package dsa_pkg;

    localparam int DEPTH_BITS_DEF = 12;
    localparam int CORDIC_STEPS   = 22;
    localparam int CW             = 34;  // cordic x/y width
    localparam int AW             = 26;  // angle accumulator width
    localparam int DW             = 49;  // |dot| width
    localparam logic signed [AW-1:0] ANG_180 = AW'(180 * 65536);

    localparam logic [1:0] REG_QUAD  = 2'd0;
    localparam logic [1:0] REG_LIN   = 2'd1;
    localparam logic [1:0] REG_CONST = 2'd2;
    localparam logic [1:0] REG_MAXL  = 2'd3;

    typedef struct packed {
        logic        neg;     // dot was negative
        logic        degen;
        logic [23:0] distance;
    } side_t;

    function automatic logic signed [AW-1:0] atan_lut(input logic [4:0] i);
        logic signed [AW-1:0] r;
        case (i)
            5'd0:  r = AW'(2949120);
            5'd1:  r = AW'(1740967);
            5'd2:  r = AW'(919879);
            5'd3:  r = AW'(466945);
            5'd4:  r = AW'(234379);
            5'd5:  r = AW'(117304);
            5'd6:  r = AW'(58666);
            5'd7:  r = AW'(29335);
            5'd8:  r = AW'(14668);
            5'd9:  r = AW'(7334);
            5'd10: r = AW'(3667);
            5'd11: r = AW'(1833);
            5'd12: r = AW'(917);
            5'd13: r = AW'(458);
            5'd14: r = AW'(229);
            5'd15: r = AW'(115);
            5'd16: r = AW'(57);
            5'd17: r = AW'(29);
            5'd18: r = AW'(14);
            5'd19: r = AW'(7);
            5'd20: r = AW'(4);
            5'd21: r = AW'(2);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/dsa_cordic_cell.sv =====
// dsa_cordic_cell: one registered vectoring step of the cordic chain
// depends on dsa_pkg
module dsa_cordic_cell
    import dsa_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 vin,
    input  logic signed [CW-1:0] xin,
    input  logic signed [CW-1:0] yin,
    input  logic signed [AW-1:0] ain,
    input  side_t                sin,
    output logic                 vout,
    output logic signed [CW-1:0] xout,
    output logic signed [CW-1:0] yout,
    output logic signed [AW-1:0] aout,
    output side_t                sout
);
    logic signed [CW-1:0] xs, ys, x_next, y_next;
    logic signed [AW-1:0] a_next;

    // shifts truncate toward zero
    always_comb
    begin
        xs = (xin < 0) ? -((-xin) >>> STEP) : (xin >>> STEP);
        ys = (yin < 0) ? -((-yin) >>> STEP) : (yin >>> STEP);
        if (yin >= 0)
        begin
            x_next = xin + ys;
            y_next = yin - xs;
            a_next = ain + atan_lut(5'(STEP));
        end
        else
        begin
            x_next = xin - ys;
            y_next = yin + xs;
            a_next = ain - atan_lut(5'(STEP));
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vout <= 1'b0;
        else if (en)
            vout <= vin;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xout <= x_next;
            yout <= y_next;
            aout <= a_next;
            sout <= sin;
        end
    end
endmodule

// ===== hw/rtl/depth_to_servo_angle_top.sv =====
// depth_to_servo_angle_top: calibration, geometry, normalize, cordic chain, output
// depends on dsa_pkg and dsa_cordic_cell
// pipeline: 7 front stages plus 22 cordic cells plus 1 output stage
// throughput: one item per cycle; the whole pipe holds when the output stalls
// the cordic chain of 22 cells sets the latency
// reset: rst_n clears all valid flags and loads the coefficient reset values
module depth_to_servo_angle_top
    import dsa_pkg::*;
#(
    parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // depth_value[11:0], lateral_position[35:12], zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // distance[23:0], angle[39:24], degenerate[40], zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    // configuration
    logic signed [31:0] quad_reg, lin_reg;
    logic signed [23:0] const_reg;
    logic [22:0]        maxl_reg;
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quad_reg  <= 32'sd6142920;
            lin_reg   <= 32'sd5432328;
            const_reg <= -24'sd14539;
            maxl_reg  <= 23'd16384;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_QUAD:  quad_reg  <= cfg_data;
                REG_LIN:   lin_reg   <= cfg_data;
                REG_CONST: const_reg <= cfg_data[23:0];
                REG_MAXL:  maxl_reg  <= cfg_data[22:0];
                default:   ;
            endcase
        end
    end

    logic en;
    logic out_v_reg;
    assign en = !out_v_reg || m_axis_tready;
    assign s_axis_tready = en;

    // stage 1: capture, q = quad*d, l = lin*d + const, clamp x
    logic v1_reg;
    logic [DEPTH_BITS-1:0] d1_reg;
    logic signed [47:0] q1_reg;
    logic signed [63:0] l1_reg;
    logic [23:0] x1_reg;
    logic [DEPTH_BITS-1:0] din;
    logic signed [23:0] lat;
    assign din = DEPTH_BITS'(s_axis_tdata[11:0]);
    assign lat = s_axis_tdata[35:12];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v1_reg <= 1'b0;
        else if (en) v1_reg <= s_axis_tvalid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_reg <= din;
            q1_reg <= 48'(quad_reg * $signed({1'b0, din}));
            l1_reg <= 64'(lin_reg * $signed({1'b0, din})) + (64'(const_reg) <<< 16);
            if (lat < 0) x1_reg <= '0;
            else if (lat > $signed({1'b0, maxl_reg})) x1_reg <= {1'b0, maxl_reg};
            else x1_reg <= lat;
        end
    end

    // stage 2: hi and lo products
    logic v2_reg;
    logic signed [63:0] hi2_reg, lo2_reg;
    logic [23:0] x2_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v2_reg <= 1'b0;
        else if (en) v2_reg <= v1_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hi2_reg <= 64'(q1_reg * $signed({1'b0, 9'(d1_reg >> 8)})) + l1_reg;
            lo2_reg <= 64'(q1_reg * $signed({1'b0, d1_reg[7:0]})) + 64'sd8388608;
            x2_reg  <= x1_reg;
        end
    end

    // stage 3: z with saturation
    logic v3_reg;
    logic signed [23:0] z3_reg;
    logic [23:0] x3_reg;
    logic signed [63:0] zsum;
    always_comb zsum = (hi2_reg + (lo2_reg >>> 8)) >>> 16;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v3_reg <= 1'b0;
        else if (en) v3_reg <= v2_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (zsum > 64'sd8388607) z3_reg <= 24'sh7fffff;
            else if (zsum < -64'sd8388608) z3_reg <= 24'sh800000;
            else z3_reg <= zsum[23:0];
            x3_reg <= x2_reg;
        end
    end

    // stage 4: products of the geometry
    logic v4_reg, dg4_reg;
    logic signed [47:0] mm4_reg, zz4_reg, zx4_reg;
    logic signed [23:0] z4_reg;
    logic signed [24:0] m2x;
    assign m2x = $signed({2'b0, maxl_reg}) - $signed({x3_reg, 1'b0});
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v4_reg <= 1'b0;
        else if (en) v4_reg <= v3_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mm4_reg <= 48'($signed({1'b0, maxl_reg}) * m2x);
            zz4_reg <= 48'(z3_reg * z3_reg);
            zx4_reg <= 48'(z3_reg * $signed({1'b0, x3_reg}));
            z4_reg  <= z3_reg;
            dg4_reg <= (z3_reg == 0) && ((maxl_reg == 0) || (m2x == 0));
        end
    end

    // stage 5: dot and |cross|
    logic v5_reg, dg5_reg, neg5_reg;
    logic [DW-1:0] dot5_reg, cr5_reg;
    logic signed [23:0] z5_reg;
    logic signed [DW+1:0] dots, crs;
    always_comb
    begin
        dots = 51'(mm4_reg) + (51'(zz4_reg) <<< 2);
        crs  = 51'(zx4_reg) <<< 2;
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v5_reg <= 1'b0;
        else if (en) v5_reg <= v4_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg5_reg <= dots < 0;
            dot5_reg <= DW'((dots < 0) ? -dots : dots);
            cr5_reg  <= DW'((crs < 0) ? -crs : crs);
            z5_reg   <= z4_reg;
            dg5_reg  <= dg4_reg;
        end
    end

    // stage 6: leading one position of the larger magnitude
    logic v6_reg, dg6_reg, neg6_reg;
    logic [DW-1:0] dot6_reg, cr6_reg;
    logic [5:0] msb6_reg;
    logic signed [23:0] z6_reg;
    logic [DW-1:0] orv;
    logic [5:0] msb;
    always_comb
    begin
        orv = dot5_reg | cr5_reg;
        msb = '0;
        for (int i = 0; i < DW; i++)
            if (orv[i]) msb = 6'(i);
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v6_reg <= 1'b0;
        else if (en) v6_reg <= v5_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dot6_reg <= dot5_reg;
            cr6_reg  <= cr5_reg;
            msb6_reg <= msb;
            neg6_reg <= neg5_reg;
            z6_reg   <= z5_reg;
            dg6_reg  <= dg5_reg || (orv == 0);
        end
    end

    // stage 7: normalize so the larger lies in [2^29, 2^30)
    logic v7_reg;
    logic signed [CW-1:0] xn7_reg, yn7_reg;
    side_t s7_reg;
    logic [CW-1:0] xn, yn;
    always_comb
    begin
        if (msb6_reg >= 6'd29)
        begin
            xn = CW'(dot6_reg >> (msb6_reg - 6'd29));
            yn = CW'(cr6_reg >> (msb6_reg - 6'd29));
        end
        else
        begin
            xn = CW'(dot6_reg) << (6'd29 - msb6_reg);
            yn = CW'(cr6_reg) << (6'd29 - msb6_reg);
        end
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v7_reg <= 1'b0;
        else if (en) v7_reg <= v6_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xn7_reg <= xn;
            yn7_reg <= yn;
            s7_reg  <= '{neg: neg6_reg, degen: dg6_reg, distance: z6_reg};
        end
    end

    // cordic chain
    logic                 cv [CORDIC_STEPS+1];
    logic signed [CW-1:0] cx [CORDIC_STEPS+1];
    logic signed [CW-1:0] cy [CORDIC_STEPS+1];
    logic signed [AW-1:0] ca [CORDIC_STEPS+1];
    side_t                cs [CORDIC_STEPS+1];
    assign cv[0] = v7_reg;
    assign cx[0] = xn7_reg;
    assign cy[0] = yn7_reg;
    assign ca[0] = '0;
    assign cs[0] = s7_reg;
    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_cell
        dsa_cordic_cell #(.STEP(g)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .vin(cv[g]), .xin(cx[g]), .yin(cy[g]), .ain(ca[g]), .sin(cs[g]),
            .vout(cv[g+1]), .xout(cx[g+1]), .yout(cy[g+1]), .aout(ca[g+1]),
            .sout(cs[g+1])
        );
    end

    // output stage: fold, clamp, round
    side_t sf;
    logic signed [AW-1:0] acc;
    logic [15:0] ang;
    logic [AW-1:0] rnd;
    logic [47:0] out_reg;
    always_comb
    begin
        sf  = cs[CORDIC_STEPS];
        acc = sf.neg ? (ANG_180 - ca[CORDIC_STEPS]) : ca[CORDIC_STEPS];
        if (acc < 0) acc = '0;
        if (acc > ANG_180) acc = ANG_180;
        rnd = (acc + AW'(128)) >> 8;
        ang = sf.degen ? 16'd0 : rnd[15:0];
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) out_v_reg <= 1'b0;
        else if (en) out_v_reg <= cv[CORDIC_STEPS];
    end
    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= {7'd0, sf.degen, ang, sf.distance};
    end
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_reg;

    // checks
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[39:24] <= 16'd46080) else $error("angle range");
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[40]) |-> m_axis_tdata[39:24] == 16'd0)
        else $error("degenerate angle");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata)) else $error("hold");
    a_norm: assert property (@(posedge clk) disable iff (!rst_n)
        (v7_reg && !s7_reg.degen) |-> (xn7_reg[CW-1:30] == 0 && yn7_reg[CW-1:30] == 0 &&
        (xn7_reg[29] || yn7_reg[29]))) else $error("normalize");
endmodule
